@@ sv/rfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RF switch frame encoder package
// Shared widths, constants, payload helpers and the configuration bundle.
// ----------------------------------------------------------------------------
package rfe_pkg;

   // Frame layout.
   localparam int          FRAME_LEN = 52;
   localparam int          POS_W     = 6;
   localparam logic [7:0]  PREAMBLE  = 8'hFE;

   // Field widths.
   localparam int HOME_W    = 4;
   localparam int ADDR_W    = 16;
   localparam int SUB_W     = 3;
   localparam int CMD_W     = 2;
   localparam int TS_W      = 8;
   localparam int ROLL_W    = 8;
   localparam int REPEAT_W  = 4;

   // Configuration port.
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   // Reset values of the configuration registers.
   localparam logic [ROLL_W-1:0]   ROLL_RESET   = 8'd152;
   localparam logic [REPEAT_W-1:0] REPEAT_RESET = 4'd5;

   // Configuration values handed from the register block to the sequencer.
   typedef struct packed {
      logic [ROLL_W-1:0]   rolling_code;
      logic [REPEAT_W-1:0] repeat_count;
   } cfg_type;

   // Subchannel number to its four-bit code; anything outside 1..5 means all.
   function automatic logic [3:0] sub_code(input logic [SUB_W-1:0] sub);
      logic [3:0] code;
      case (sub)
         3'd1:    code = 4'h8;
         3'd2:    code = 4'h4;
         3'd3:    code = 4'h2;
         3'd4:    code = 4'h1;
         3'd5:    code = 4'h3;
         default: code = 4'h0;
      endcase
      return code;
   endfunction

   // Assemble the 52-bit frame, most significant bit sent first.
   function automatic logic [FRAME_LEN-1:0] build_frame(
      input logic [HOME_W-1:0] home,
      input logic [ADDR_W-1:0] address,
      input logic [SUB_W-1:0]  subchannel,
      input logic [CMD_W-1:0]  command,
      input logic [ROLL_W-1:0] rolling_code,
      input logic [TS_W-1:0]   timestamp
   );
      return {PREAMBLE, home, address, sub_code(subchannel), 2'b00, command,
              rolling_code, timestamp};
   endfunction

endpackage

@@ sv/rfe_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RF switch frame encoder channels
// Valid/ready interfaces for the request items and the result items.
// ----------------------------------------------------------------------------
interface rfe_req_if;
   import rfe_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [HOME_W-1:0] home;
   logic [ADDR_W-1:0] address;
   logic [SUB_W-1:0]  subchannel;
   logic [CMD_W-1:0]  command;
   logic [TS_W-1:0]   timestamp;

   modport source (output valid, func, home, address, subchannel, command, timestamp,
                   input ready);
   modport sink (input valid, func, home, address, subchannel, command, timestamp,
                 output ready);
endinterface

interface rfe_rsp_if;
   logic valid;
   logic ready;
   logic tx_level;
   logic busy_res;
   logic start_rejected;
   logic frame_done;

   modport source (output valid, tx_level, busy_res, start_rejected, frame_done,
                   input ready);
   modport sink (input valid, tx_level, busy_res, start_rejected, frame_done,
                 output ready);
endinterface

@@ sv/rfe_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RF switch frame encoder registers
// APB-style register block holding the rolling code and the repeat count.
// ----------------------------------------------------------------------------
module rfe_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rfe_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [rfe_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [rfe_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready,
   output rfe_pkg::cfg_type                cfg
);
   import rfe_pkg::*;

   // Register index, taken from the word address bit.
   localparam logic REG_ROLLING = 1'b0;
   localparam logic REG_REPEAT  = 1'b1;

   logic [ROLL_W-1:0]   rolling_ff;
   logic [ROLL_W-1:0]   rolling_in;
   logic [REPEAT_W-1:0] repeat_ff;
   logic [REPEAT_W-1:0] repeat_in;
   logic                wr_en;
   logic                reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   // Write decode.
   always_comb begin
      rolling_in = rolling_ff;
      repeat_in  = repeat_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_ROLLING: rolling_in = pwdata[ROLL_W-1:0];
            REG_REPEAT:  repeat_in  = pwdata[REPEAT_W-1:0];
            default:     rolling_in = rolling_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rolling_ff <= ROLL_RESET;
         repeat_ff  <= REPEAT_RESET;
      end else begin
         rolling_ff <= rolling_in;
         repeat_ff  <= repeat_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_sel)
         REG_ROLLING: prdata = APB_DATA_W'(rolling_ff);
         REG_REPEAT:  prdata = APB_DATA_W'(repeat_ff);
         default:     prdata = '0;
      endcase
   end

   assign cfg.rolling_code = rolling_ff;
   assign cfg.repeat_count = repeat_ff;

endmodule

@@ sv/rfe_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RF switch frame encoder sequencer
// Segment state machine advanced once per accepted item, with a result register.
// ----------------------------------------------------------------------------
module rfe_seq (
   input  logic             clock,
   input  logic             reset,
   input  rfe_pkg::cfg_type cfg,
   rfe_req_if.sink          req_chan,
   rfe_rsp_if.source        rsp_chan
);
   import rfe_pkg::*;

   // Segment codes.
   localparam logic [2:0] SEG_IDLE    = 3'd0;
   localparam logic [2:0] SEG_SYNC_LO = 3'd1;
   localparam logic [2:0] SEG_SYNC_HI = 3'd2;
   localparam logic [2:0] SEG_BIT_LO  = 3'd3;
   localparam logic [2:0] SEG_BIT_HI  = 3'd4;
   localparam logic [2:0] SEG_GAP     = 3'd5;

   localparam logic [3:0] SYNC_HIGH_UNITS = 4'd6;
   localparam logic [3:0] GAP_UNITS       = 4'd14;

   logic [FRAME_LEN-1:0] frame_ff, frame_in;
   logic [POS_W-1:0]     bitpos_ff, bitpos_in;
   logic [2:0]           seg_ff, seg_in;
   logic [3:0]           units_ff, units_in;
   logic [REPEAT_W-1:0]  frames_ff, frames_in;

   logic rsp_valid_ff;
   logic level_ff, busy_ff, rej_ff, done_ff;
   logic level_in, busy_in, rej_in, done_in;

   logic             accept;
   logic             active;
   logic [POS_W-1:0] nxt_pos;
   logic             cur_bit;
   logic             nxt_bit;

   // Take an item whenever the result register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign active = (seg_ff >= SEG_SYNC_LO) && (seg_ff <= SEG_GAP);

   // Bit under the current position and the one after it.
   assign nxt_pos = bitpos_ff + POS_W'(1);
   assign cur_bit = frame_ff[POS_W'(FRAME_LEN - 1) - bitpos_ff];
   assign nxt_bit = (nxt_pos < POS_W'(FRAME_LEN)) ?
                    frame_ff[POS_W'(FRAME_LEN - 1) - nxt_pos] : 1'b0;

   // Next state and result for one item.
   always_comb begin
      frame_in  = frame_ff;
      bitpos_in = bitpos_ff;
      seg_in    = active ? seg_ff : SEG_IDLE;
      units_in  = units_ff;
      frames_in = frames_ff;
      level_in  = 1'b0;
      busy_in   = 1'b0;
      rej_in    = 1'b0;
      done_in   = 1'b0;
      if (req_chan.func) begin
         busy_in = 1'b1;
         if (active) begin
            rej_in = 1'b1;
         end else begin
            frame_in  = build_frame(req_chan.home, req_chan.address, req_chan.subchannel,
                                    req_chan.command, cfg.rolling_code,
                                    req_chan.timestamp);
            bitpos_in = '0;
            seg_in    = SEG_SYNC_LO;
            units_in  = 4'd1;
            frames_in = cfg.repeat_count;
         end
      end else if (active) begin
         busy_in  = 1'b1;
         level_in = (seg_ff == SEG_SYNC_HI) || (seg_ff == SEG_BIT_HI);
         if (units_ff > 4'd1) begin
            units_in = units_ff - 4'd1;
         end else begin
            unique case (seg_ff)
               SEG_SYNC_LO: begin
                  seg_in   = SEG_SYNC_HI;
                  units_in = SYNC_HIGH_UNITS;
               end
               SEG_SYNC_HI: begin
                  bitpos_in = '0;
                  seg_in    = SEG_BIT_LO;
                  units_in  = frame_ff[FRAME_LEN-1] ? 4'd1 : 4'd2;
               end
               SEG_BIT_LO: begin
                  seg_in   = SEG_BIT_HI;
                  units_in = cur_bit ? 4'd2 : 4'd1;
               end
               SEG_BIT_HI: begin
                  if (nxt_pos < POS_W'(FRAME_LEN)) begin
                     bitpos_in = nxt_pos;
                     seg_in    = SEG_BIT_LO;
                     units_in  = nxt_bit ? 4'd1 : 4'd2;
                  end else begin
                     bitpos_in = '0;
                     seg_in    = SEG_GAP;
                     units_in  = GAP_UNITS;
                  end
               end
               default: begin
                  // End of a repetition gap: either go again or finish.
                  if (frames_ff == '0) begin
                     seg_in   = SEG_IDLE;
                     units_in = '0;
                     done_in  = 1'b1;
                  end else begin
                     frames_in = frames_ff - REPEAT_W'(1);
                     seg_in    = SEG_SYNC_LO;
                     units_in  = 4'd1;
                  end
               end
            endcase
         end
      end
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         bitpos_ff <= '0;
         seg_ff    <= SEG_IDLE;
         units_ff  <= '0;
         frames_ff <= '0;
      end else if (accept) begin
         frame_ff  <= frame_in;
         bitpos_ff <= bitpos_in;
         seg_ff    <= seg_in;
         units_ff  <= units_in;
         frames_ff <= frames_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         level_ff <= level_in;
         busy_ff  <= busy_in;
         rej_ff   <= rej_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.tx_level       = level_ff;
   assign rsp_chan.busy_res       = busy_ff;
   assign rsp_chan.start_rejected = rej_ff;
   assign rsp_chan.frame_done     = done_ff;

   // A running segment always has at least one unit left.
   a_units_nonzero: assert property (@(posedge clock) disable iff (reset)
      active |-> (units_ff != 4'd0))
      else $error("active segment with no units left");

   // The bit position never runs past the frame.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      bitpos_ff < POS_W'(FRAME_LEN))
      else $error("bit position beyond frame");

   // A start taken while idle opens with the sync low unit.
   a_start_sync: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.func && !active) |=> (seg_ff == SEG_SYNC_LO) && (units_ff == 4'd1))
      else $error("start did not enter sync low");

   // A rejected start or a finished frame is always reported as busy.
   a_flags_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rej_ff || done_ff)) |-> busy_ff)
      else $error("reject or done flag without busy");

endmodule

@@ sv/rf_pwm_switch_frame_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RF switch frame encoder top level
// A result item is registered and valid in the cycle after its request item is taken.
// Throughput: one item per clock while results drain, a sequencer step each.
// The result register decouples the two channels, so a new item is taken
// while a finished result waits, as long as the result is drained that cycle.
// Reset (synchronous, active high) returns the sequencer to idle and loads
// rolling code 152 and repeat count 5.
// ----------------------------------------------------------------------------
module rf_pwm_switch_frame_encoder_top (
   input  logic                            clock,
   input  logic                            reset,
   rfe_req_if.sink                         req_chan,
   rfe_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rfe_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [rfe_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [rfe_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import rfe_pkg::*;

   cfg_type cfg;

   // Configuration registers.
   rfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Segment sequencer and result register.
   rfe_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
